// ===== sv/cursor_autohide_controller_defines.svh =====
// Assertion macros used by the cursor auto-hide controller back end.
`ifndef CURSOR_AUTOHIDE_CONTROLLER_DEFINES_SVH
`define CURSOR_AUTOHIDE_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
`define CAC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CAC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CAC_ASSERT(name, clk, rst_n, prop, msg)
`define CAC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/cac_pkg.sv =====
// Types and constants shared by the cursor auto-hide controller modules.
`default_nettype none
package cac_pkg;

  // Item action codes.
  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_TICK   = 2'd1;
  localparam logic [1:0] ACT_FOCUS  = 2'd2;

  // Visibility phase codes.
  localparam logic [1:0] PH_VISIBLE      = 2'd0;
  localparam logic [1:0] PH_PEND_HIDDEN  = 2'd1;
  localparam logic [1:0] PH_HIDDEN       = 2'd2;
  localparam logic [1:0] PH_PEND_VISIBLE = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_MONITOR_LEFT    = 3'd0;
  localparam logic [2:0] REG_MONITOR_TOP     = 3'd1;
  localparam logic [2:0] REG_MONITOR_WIDTH   = 3'd2;
  localparam logic [2:0] REG_MONITOR_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_SHOW_ZONE_LIMIT = 3'd4;
  localparam logic [2:0] REG_HIDE_ZONE_LIMIT = 3'd5;
  localparam logic [2:0] REG_SHOW_DELAY_MS   = 3'd6;
  localparam logic [2:0] REG_HIDE_DELAY_MS   = 3'd7;

  localparam logic [15:0] MIN_DELAY_MS = 16'd10;

  // What the front end found an item to be.
  typedef enum logic [2:0] {
    CLS_NONE,   // sample outside the monitor, or an unused action code
    CLS_SHOW,   // sample in the top zone
    CLS_HIDE,   // sample below the hide limit
    CLS_MID,    // sample between the two zones
    CLS_TICK,
    CLS_FOCUS
  } cls_e;

  typedef struct packed {
    logic signed [15:0] monitor_left;
    logic signed [15:0] monitor_top;
    logic [14:0]        monitor_width;
    logic [14:0]        monitor_height;
    logic [14:0]        show_zone_limit;
    logic [14:0]        hide_zone_limit;
    logic [15:0]        show_delay_ms;
    logic [15:0]        hide_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic valid;
    cls_e cls;
  } q_out_t;

endpackage
`default_nettype wire

// ===== sv/cac_front.sv =====
// Front end: classifies each incoming item against the monitor rectangle and zones.
`default_nettype none
module cac_front (
  input  wire logic               [1:0]  action_i,
  input  wire logic signed        [15:0] cursor_x_i,
  input  wire logic signed        [15:0] cursor_y_i,
  input  wire cac_pkg::cfg_t             cfg_i,
  output cac_pkg::cls_e                  cls_o
);

  logic signed [16:0] x_ext, y_ext, left_ext, top_ext, right_ext, bottom_ext;
  logic signed [16:0] rel_y, show_ext, hide_ext;
  logic               in_rect;

  // 17-bit signed arithmetic keeps the right and bottom edges from wrapping.
  assign x_ext      = {cursor_x_i[15], cursor_x_i};
  assign y_ext      = {cursor_y_i[15], cursor_y_i};
  assign left_ext   = {cfg_i.monitor_left[15], cfg_i.monitor_left};
  assign top_ext    = {cfg_i.monitor_top[15], cfg_i.monitor_top};
  assign right_ext  = left_ext + $signed({2'b00, cfg_i.monitor_width});
  assign bottom_ext = top_ext + $signed({2'b00, cfg_i.monitor_height});
  assign rel_y      = y_ext - top_ext;
  assign show_ext   = {2'b00, cfg_i.show_zone_limit};
  assign hide_ext   = {2'b00, cfg_i.hide_zone_limit};

  assign in_rect = (x_ext >= left_ext) && (x_ext < right_ext) &&
                   (y_ext >= top_ext) && (y_ext < bottom_ext);

  always_comb begin
    case (action_i)
      cac_pkg::ACT_SAMPLE: begin
        if (!in_rect) begin
          cls_o = cac_pkg::CLS_NONE;
        end else if (rel_y <= show_ext) begin
          cls_o = cac_pkg::CLS_SHOW;
        end else if (rel_y > hide_ext) begin
          cls_o = cac_pkg::CLS_HIDE;
        end else begin
          cls_o = cac_pkg::CLS_MID;
        end
      end
      cac_pkg::ACT_TICK:  cls_o = cac_pkg::CLS_TICK;
      cac_pkg::ACT_FOCUS: cls_o = cac_pkg::CLS_FOCUS;
      default:            cls_o = cac_pkg::CLS_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/cac_queue.sv =====
// Short queue of classified items between the front end and the back end.
`default_nettype none
module cac_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire cac_pkg::cls_e     cls_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output cac_pkg::q_out_t        q_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cac_pkg::cls_e entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o   = (count_q == CntW'(Depth));
  assign q_o.valid = (count_q != '0);
  assign q_o.cls   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cls_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/cac_back.sv =====
// Back end: visibility state machine, elapsed-time counter and result register.
`default_nettype none
`include "cursor_autohide_controller_defines.svh"
module cac_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cac_pkg::q_out_t   q_i,
  output logic                   pop_o,
  input  wire cac_pkg::cfg_t     cfg_i,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic                   bar_shown_o,
  output logic [1:0]             vis_state_o,
  output logic                   update_pulse_o
);

  logic [1:0]  ph_q, ph_d, ph_mid;
  logic        armed_q, armed_d;
  logic [15:0] el_q, el_d, el_mid;
  logic [15:0] show_eff, hide_eff;
  logic        pulse_d;
  logic        out_valid_q, out_valid_d;
  logic        bar_shown_q, pulse_q;
  logic [1:0]  vis_state_q;
  logic        is_sample;

  assign show_eff = (cfg_i.show_delay_ms < cac_pkg::MIN_DELAY_MS) ?
                    cac_pkg::MIN_DELAY_MS : cfg_i.show_delay_ms;
  assign hide_eff = (cfg_i.hide_delay_ms < cac_pkg::MIN_DELAY_MS) ?
                    cac_pkg::MIN_DELAY_MS : cfg_i.hide_delay_ms;

  // The result register frees up whenever it is empty or being taken.
  assign pop_o = q_i.valid && (!out_valid_q || out_ready_i);

  assign is_sample = (q_i.cls == cac_pkg::CLS_SHOW) || (q_i.cls == cac_pkg::CLS_HIDE) ||
                     (q_i.cls == cac_pkg::CLS_MID);

  always_comb begin
    ph_mid  = ph_q;
    el_mid  = el_q;
    armed_d = armed_q;
    case (q_i.cls)
      cac_pkg::CLS_SHOW: begin
        // Only the second top-zone sample in a row starts a pending show.
        if (armed_q && (ph_q == cac_pkg::PH_HIDDEN || ph_q == cac_pkg::PH_PEND_HIDDEN)) begin
          ph_mid = cac_pkg::PH_PEND_VISIBLE;
          el_mid = '0;
        end
        armed_d = 1'b1;
      end
      cac_pkg::CLS_HIDE: begin
        if (ph_q == cac_pkg::PH_VISIBLE || ph_q == cac_pkg::PH_PEND_VISIBLE) begin
          ph_mid = cac_pkg::PH_PEND_HIDDEN;
          el_mid = '0;
        end
        armed_d = 1'b0;
      end
      cac_pkg::CLS_MID: armed_d = 1'b0;
      default: ;
    endcase
  end

  always_comb begin
    ph_d    = ph_mid;
    el_d    = el_mid;
    pulse_d = 1'b0;
    if (is_sample) begin
      if (ph_mid == cac_pkg::PH_PEND_VISIBLE && el_mid >= show_eff) begin
        ph_d    = cac_pkg::PH_VISIBLE;
        pulse_d = 1'b1;
      end else if (ph_mid == cac_pkg::PH_PEND_HIDDEN && el_mid >= hide_eff) begin
        ph_d    = cac_pkg::PH_HIDDEN;
        pulse_d = 1'b1;
      end
    end else if (q_i.cls == cac_pkg::CLS_TICK) begin
      if (el_q != '1) begin
        el_d = el_q + 1'b1;
      end
    end else if (q_i.cls == cac_pkg::CLS_FOCUS) begin
      ph_d    = cac_pkg::PH_VISIBLE;
      pulse_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= cac_pkg::PH_VISIBLE;
      armed_q     <= 1'b0;
      el_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        ph_q    <= ph_d;
        armed_q <= armed_d;
        el_q    <= el_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      vis_state_q <= ph_d;
      bar_shown_q <= (ph_d == cac_pkg::PH_VISIBLE) || (ph_d == cac_pkg::PH_PEND_HIDDEN);
      pulse_q     <= pulse_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign vis_state_o    = vis_state_q;
  assign bar_shown_o    = bar_shown_q;
  assign update_pulse_o = pulse_q;

  `CAC_ASSERT(a_pulse_lands_settled, clk_i, rst_ni, pop_o && pulse_d |-> (ph_d == cac_pkg::PH_VISIBLE || ph_d == cac_pkg::PH_HIDDEN), "update pulse with a pending phase")
  `CAC_ASSERT_NEXT(a_el_saturates, clk_i, rst_ni, pop_o && q_i.cls == cac_pkg::CLS_TICK && el_q == 16'hFFFF, el_q == 16'hFFFF, "elapsed counter wrapped")
  `CAC_ASSERT_NEXT(a_focus_visible, clk_i, rst_ni, pop_o && q_i.cls == cac_pkg::CLS_FOCUS, ph_q == cac_pkg::PH_VISIBLE && vis_state_o == cac_pkg::PH_VISIBLE, "focus change did not show the bar")
  `CAC_ASSERT_NEXT(a_hide_starts_pending, clk_i, rst_ni, pop_o && q_i.cls == cac_pkg::CLS_HIDE && ph_q == cac_pkg::PH_VISIBLE, ph_q == cac_pkg::PH_PEND_HIDDEN && el_q == 16'd0, "hide trigger did not start a pending hide")

endmodule
`default_nettype wire

// ===== sv/cursor_autohide_controller.sv =====
// Top level of the cursor auto-hide controller: configuration registers and wiring.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_ready_o   action_i, cursor_x_i, cursor_y_i
//   out       output     out_valid_o / out_ready_i bar_shown_o, vis_state_o, update_pulse_o
//   cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item is accepted per cycle while the queue is not full; each item is written
// to a queue entry and then to the result register. The front end classifies in the
// accept cycle; the back end updates state and loads the result register when it
// pops the queue. With the output stalled, QueueDepth items wait in the queue and one
// in the result register before the input stalls.
// Reset returns the visibility phase to visible, clears the counter and loads register defaults.
`default_nettype none
module cursor_autohide_controller #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic        [1:0]  action_i,
  input  wire logic signed [15:0] cursor_x_i,
  input  wire logic signed [15:0] cursor_y_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    bar_shown_o,
  output logic             [1:0]  vis_state_o,
  output logic                    update_pulse_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic        [2:0]  cfg_index_i,
  input  wire logic        [15:0] cfg_data_i
);

  cac_pkg::cfg_t   cfg_q;
  cac_pkg::cls_e   front_cls;
  cac_pkg::q_out_t q_head;
  logic            q_full, push, pop;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full;
  assign push        = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.monitor_left    <= 16'sd0;
      cfg_q.monitor_top     <= 16'sd0;
      cfg_q.monitor_width   <= 15'd1920;
      cfg_q.monitor_height  <= 15'd1080;
      cfg_q.show_zone_limit <= 15'd1;
      cfg_q.hide_zone_limit <= 15'd50;
      cfg_q.show_delay_ms   <= 16'd0;
      cfg_q.hide_delay_ms   <= 16'd3000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cac_pkg::REG_MONITOR_LEFT:    cfg_q.monitor_left    <= cfg_data_i;
        cac_pkg::REG_MONITOR_TOP:     cfg_q.monitor_top     <= cfg_data_i;
        cac_pkg::REG_MONITOR_WIDTH:   cfg_q.monitor_width   <= cfg_data_i[14:0];
        cac_pkg::REG_MONITOR_HEIGHT:  cfg_q.monitor_height  <= cfg_data_i[14:0];
        cac_pkg::REG_SHOW_ZONE_LIMIT: cfg_q.show_zone_limit <= cfg_data_i[14:0];
        cac_pkg::REG_HIDE_ZONE_LIMIT: cfg_q.hide_zone_limit <= cfg_data_i[14:0];
        cac_pkg::REG_SHOW_DELAY_MS:   cfg_q.show_delay_ms   <= cfg_data_i;
        cac_pkg::REG_HIDE_DELAY_MS:   cfg_q.hide_delay_ms   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cac_front u_front (
    .action_i   (action_i),
    .cursor_x_i (cursor_x_i),
    .cursor_y_i (cursor_y_i),
    .cfg_i      (cfg_q),
    .cls_o      (front_cls)
  );

  cac_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cls_i  (front_cls),
    .full_o (q_full),
    .pop_i  (pop),
    .q_o    (q_head)
  );

  cac_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_i            (q_head),
    .pop_o          (pop),
    .cfg_i          (cfg_q),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .bar_shown_o    (bar_shown_o),
    .vis_state_o    (vis_state_o),
    .update_pulse_o (update_pulse_o)
  );

endmodule
`default_nettype wire
